FILE: sv/rfsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsc_pkg
// Shared types and constants of the feedback stream cipher.
// ----------------------------------------------------------------------------
package rfsc_pkg;

   localparam int unsigned TABLE_DEPTH = 256;
   localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned KLEN_W      = 5;
   localparam int unsigned MAX_KEY     = 20;
   localparam int unsigned KEY_VEC_W   = MAX_KEY * BYTE_W;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
   localparam logic [KLEN_W-1:0] KLEN_MAX  = KLEN_W'(MAX_KEY);
   localparam logic [KLEN_W-1:0] KLEN_MIN  = KLEN_W'(1);
   localparam logic [KLEN_W-1:0] KLEN_RST  = KLEN_W'(16);

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_MID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LEN  = 2'd3;

   localparam logic OP_KEY_SCHED = 1'b0;
   localparam logic OP_DATA      = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_RD_I,
      ST_RD_J,
      ST_WR_I,
      ST_WR_J
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [BYTE_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

endpackage

FILE: sv/rfsc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsc_req_if
// Request channel: key schedule or data byte beats.
// ----------------------------------------------------------------------------
interface rfsc_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;
   logic       encrypt;

   modport source (output valid, output op, output data_byte, output encrypt,
                   input ready);
   modport sink (input valid, input op, input data_byte, input encrypt,
                 output ready);
endinterface

interface rfsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] result_byte;
   logic       was_key_schedule;

   modport source (output valid, output result_byte, output was_key_schedule,
                   input ready);
   modport sink (input valid, input result_byte, input was_key_schedule,
                 output ready);
endinterface

FILE: sv/rfsc_perm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsc_perm_ram
// Permutation table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rfsc_perm_ram
   import rfsc_pkg::*;
(
   input  logic              clock,
   input  ram_req_type       ram_req,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [TABLE_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rd_data_ff <= mem[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/rc4_feedback_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_feedback_stream_cipher
// RC4 byte stream cipher with an extra XOR feedback byte.
// ----------------------------------------------------------------------------
// Usage:
//   Load the key through the csr_ port (key bytes 0..19 over three registers,
//   key length 1..20) while the block is idle, then send a key schedule beat
//   (op = 0) on req_bus. It fills the 256-entry permutation table, then runs
//   the key schedule with a read of S[i], a read of S[j] and two swap writes
//   per entry, and then gives its rsp_bus beat (result 0, flag set).
//   Each data beat (op = 1) then runs the same steps plus a keystream read and
//   gives one rsp_bus beat; the next beat is taken only when the block is idle again.
//   The step order is set by the table memory: three dependent reads from its
//   registered read port and two swap writes on its single write port.
//   A finished result sits in an output register; the next beat is taken
//   while it waits. If rsp_bus stalls with a result still held, the
//   sequencer holds its last step until the register frees up.
//   Reset clears the indices, the feedback byte and the key registers
//   (length 16); the table holds no defined content until a key schedule.
// ----------------------------------------------------------------------------
module rc4_feedback_stream_cipher
   import rfsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rfsc_req_if.sink              req_bus,
   rfsc_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  i_ff, i_in;
   logic [ADDR_W-1:0]  j_ff, j_in;
   logic [BYTE_W-1:0]  si_ff, si_in;
   logic [BYTE_W-1:0]  sj_ff, sj_in;
   logic [BYTE_W-1:0]  fb_ff, fb_in;
   logic [KLEN_W-1:0]  k_ff, k_in;
   logic               mode_ff, mode_in;
   logic               enc_ff, enc_in;
   logic [BYTE_W-1:0]  data_ff, data_in;
   logic               hit_i_ff, hit_i_in;
   logic               hit_j_ff, hit_j_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_ks_ff, rsp_ks_in;

   logic [63:0]        key_low_ff;
   logic [63:0]        key_mid_ff;
   logic [31:0]        key_high_ff;
   logic [KLEN_W-1:0]  key_len_ff;

   ram_req_type        ram_req;
   logic [BYTE_W-1:0]  rd_data;

   logic [KEY_VEC_W-1:0] key_vec;
   logic [BYTE_W-1:0]    key_byte;
   logic [KLEN_W-1:0]    len_eff;
   logic                 out_free;
   logic                 accept;
   logic                 finish;

   rfsc_perm_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign key_vec  = {key_high_ff, key_mid_ff, key_low_ff};
   assign key_byte = key_vec[{k_ff, 3'b000} +: BYTE_W];
   assign len_eff  = (key_len_ff == '0)      ? KLEN_MIN :
                     (key_len_ff > KLEN_MAX) ? KLEN_MAX : key_len_ff;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign accept   = req_bus.valid && req_bus.ready;
   assign finish   = (mode_ff == OP_DATA) || (i_ff == LAST_ADDR);

   assign req_bus.ready            = (state_ff == ST_IDLE);
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.result_byte      = rsp_byte_ff;
   assign rsp_bus.was_key_schedule = rsp_ks_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_bus.op == OP_DATA) ? ST_RD_J : ST_FILL;
            end
         end
         ST_FILL: begin
            if (i_ff == LAST_ADDR) begin
               state_in = ST_RD_I;
            end
         end
         ST_RD_I: state_in = ST_RD_J;
         ST_RD_J: state_in = ST_WR_I;
         ST_WR_I: state_in = ST_WR_J;
         ST_WR_J: begin
            if (!finish) begin
               state_in = ST_RD_I;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      logic [ADDR_W-1:0] j_new;
      logic [ADDR_W-1:0] ks_addr;
      logic [BYTE_W-1:0] ks;
      logic [BYTE_W-1:0] res;
      logic [KLEN_W-1:0] k_next;

      j_new   = '0;
      ks_addr = '0;
      ks      = '0;
      res     = '0;
      k_next  = k_ff + KLEN_W'(1);

      i_in     = i_ff;
      j_in     = j_ff;
      si_in    = si_ff;
      sj_in    = sj_ff;
      fb_in    = fb_ff;
      k_in     = k_ff;
      mode_in  = mode_ff;
      enc_in   = enc_ff;
      data_in  = data_ff;
      hit_i_in = hit_i_ff;
      hit_j_in = hit_j_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_ks_in    = rsp_ks_ff;

      ram_req = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in = req_bus.op;
               enc_in  = req_bus.encrypt;
               data_in = req_bus.data_byte;
               if (req_bus.op == OP_DATA) begin
                  i_in          = i_ff + ADDR_W'(1);
                  ram_req.re    = 1'b1;
                  ram_req.raddr = i_ff + ADDR_W'(1);
               end else begin
                  i_in = '0;
                  j_in = '0;
               end
            end
         end
         ST_FILL: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = i_ff;
            ram_req.wdata = i_ff;
            i_in          = i_ff + ADDR_W'(1);
            k_in          = '0;
         end
         ST_RD_I: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = i_ff;
         end
         ST_RD_J: begin
            j_new = j_ff + rd_data + ((mode_ff == OP_DATA) ? BYTE_W'(0) : key_byte);
            si_in         = rd_data;
            j_in          = j_new;
            ram_req.re    = 1'b1;
            ram_req.raddr = j_new;
         end
         ST_WR_I: begin
            sj_in         = rd_data;
            ram_req.we    = 1'b1;
            ram_req.waddr = i_ff;
            ram_req.wdata = rd_data;
            ks_addr       = si_ff + rd_data;
            hit_i_in      = (ks_addr == i_ff);
            hit_j_in      = (ks_addr == j_ff);
            ram_req.re    = (mode_ff == OP_DATA);
            ram_req.raddr = ks_addr;
         end
         ST_WR_J: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = j_ff;
            ram_req.wdata = si_ff;
            ks  = hit_i_ff ? sj_ff : (hit_j_ff ? si_ff : rd_data);
            res = data_ff ^ ks ^ fb_ff;
            if (!finish) begin
               i_in = i_ff + ADDR_W'(1);
               k_in = (k_next >= len_eff) ? '0 : k_next;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               if (mode_ff == OP_DATA) begin
                  rsp_byte_in = res;
                  rsp_ks_in   = 1'b0;
                  fb_in       = fb_ff ^ (enc_ff ? data_ff : res);
               end else begin
                  rsp_byte_in = '0;
                  rsp_ks_in   = 1'b1;
                  fb_in       = key_low_ff[BYTE_W-1:0];
                  i_in        = '0;
                  j_in        = '0;
               end
            end
         end
         default: ram_req = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         fb_ff        <= '0;
         k_ff         <= '0;
         mode_ff      <= OP_KEY_SCHED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         fb_ff        <= fb_in;
         k_ff         <= k_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      enc_ff      <= enc_in;
      data_ff     <= data_in;
      hit_i_ff    <= hit_i_in;
      hit_j_ff    <= hit_j_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_ks_ff   <= rsp_ks_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_mid_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= KLEN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_KEY_MID:  key_mid_ff  <= csr_wdata;
            CSR_KEY_HIGH: key_high_ff <= csr_wdata[31:0];
            CSR_KEY_LEN:  key_len_ff  <= csr_wdata[KLEN_W-1:0];
            default:      key_len_ff  <= key_len_ff;
         endcase
      end
   end

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ram_req.we)
      else $error("table written while idle");

   a_data_enters_swap: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.op == OP_DATA) |=> (state_ff == ST_RD_J && mode_ff == OP_DATA))
      else $error("data beat did not start the swap");

   a_ks_index_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR_J && state_in == ST_RD_I) |=> i_ff == $past(i_ff) + ADDR_W'(1))
      else $error("key schedule index did not advance");

   a_ks_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ks_ff) |-> rsp_byte_ff == '0)
      else $error("key schedule beat carries data");

   a_key_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_J && mode_ff == OP_KEY_SCHED) |-> k_ff < len_eff)
      else $error("key byte index out of range");

endmodule

FILE: dv/rc4_feedback_stream_cipher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_feedback_stream_cipher_tb
// Sends key schedule and data beats into the feedback stream cipher and
// tracks a shadow copy of the permutation table, both indices, the feedback
// byte and the key registers. Each response beat is checked field by field
// against that shadow. Idle and stall patterns on both channels vary across
// the run, and one long response hold-off backs up the request side.
// ----------------------------------------------------------------------------
module rc4_feedback_stream_cipher_tb
   import rfsc_pkg::*;
();

   typedef struct packed {
      logic [BYTE_W-1:0] result_byte;
      logic              was_key_schedule;
   } cipher_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rfsc_req_if req_bus ();
   rfsc_rsp_if rsp_bus ();

   rc4_feedback_stream_cipher i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [BYTE_W-1:0] perm_table [TABLE_DEPTH];
   logic [BYTE_W-1:0] step_ix  = '0;
   logic [BYTE_W-1:0] mix_ix   = '0;
   logic [BYTE_W-1:0] feedback = '0;
   logic [63:0]       key_low  = '0;
   logic [63:0]       key_mid  = '0;
   logic [31:0]       key_high = '0;
   logic [KLEN_W-1:0] key_len  = KLEN_RST;

   cipher_result_type pending_results [$];
   int unsigned mismatch_count = 0;
   int unsigned src_idle_pct   = 0;
   int unsigned sink_stall_pct = 0;
   int unsigned hold_cycles    = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [BYTE_W-1:0] key_byte_at(int unsigned n);
      if (n < 8) return key_low[8*n +: 8];
      if (n < 16) return key_mid[8*(n-8) +: 8];
      if (n < MAX_KEY) return key_high[8*(n-16) +: 8];
      return '0;
   endfunction

   function automatic void run_key_schedule();
      int unsigned len;
      int unsigned k;
      logic [BYTE_W-1:0] j;
      logic [BYTE_W-1:0] t;
      len = key_len;
      if (len == 0) len = 1;
      if (len > MAX_KEY) len = MAX_KEY;
      for (int i = 0; i < TABLE_DEPTH; i++) perm_table[i] = 8'(i);
      k = 0;
      j = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         j = j + key_byte_at(k) + perm_table[i];
         t = perm_table[i];
         perm_table[i] = perm_table[j];
         perm_table[j] = t;
         k++;
         if (k >= len) k = 0;
      end
      feedback = key_byte_at(0);
      step_ix  = '0;
      mix_ix   = '0;
   endfunction

   function automatic logic [BYTE_W-1:0] crypt_byte(logic [BYTE_W-1:0] d, logic enc);
      logic [BYTE_W-1:0] t;
      logic [BYTE_W-1:0] ks;
      logic [BYTE_W-1:0] r;
      step_ix = step_ix + 8'd1;
      mix_ix  = mix_ix + perm_table[step_ix];
      t = perm_table[step_ix];
      perm_table[step_ix] = perm_table[mix_ix];
      perm_table[mix_ix]  = t;
      ks = perm_table[8'(perm_table[step_ix] + perm_table[mix_ix])];
      r  = d ^ ks ^ feedback;
      feedback = feedback ^ (enc ? d : r);
      return r;
   endfunction

   function automatic cipher_result_type predict_cipher(logic op, logic [BYTE_W-1:0] d,
                                                        logic enc);
      cipher_result_type res;
      if (op == OP_KEY_SCHED) begin
         run_key_schedule();
         res.result_byte      = '0;
         res.was_key_schedule = 1'b1;
      end else begin
         res.result_byte      = crypt_byte(d, enc);
         res.was_key_schedule = 1'b0;
      end
      return res;
   endfunction

   task automatic load_key(input logic [63:0] low_word, input logic [63:0] mid_word,
                           input logic [63:0] high_word, input logic [63:0] len_word);
      csr_we    <= 1'b1;
      csr_index <= CSR_KEY_LOW;
      csr_wdata <= low_word;
      @(posedge clock);
      csr_index <= CSR_KEY_MID;
      csr_wdata <= mid_word;
      @(posedge clock);
      csr_index <= CSR_KEY_HIGH;
      csr_wdata <= high_word;
      @(posedge clock);
      csr_index <= CSR_KEY_LEN;
      csr_wdata <= len_word;
      @(posedge clock);
      csr_we   <= 1'b0;
      key_low  = low_word;
      key_mid  = mid_word;
      key_high = high_word[31:0];
      key_len  = len_word[KLEN_W-1:0];
   endtask

   task automatic send_beat(input logic op, input logic [BYTE_W-1:0] d, input logic enc,
                            output logic [BYTE_W-1:0] predicted);
      cipher_result_type res;
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.op        <= op;
      req_bus.data_byte <= d;
      req_bus.encrypt   <= enc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      res = predict_cipher(op, d, enc);
      pending_results.push_back(res);
      predicted = res.result_byte;
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_key_extremes();
      logic [BYTE_W-1:0] dummy;
      // zero length acts as one
      load_key('0, '0, '0, 64'd0);
      send_beat(OP_KEY_SCHED, 8'hff, 1'b1, dummy);
      send_beat(OP_DATA, 8'h00, 1'b1, dummy);
      send_beat(OP_DATA, 8'hff, 1'b0, dummy);
      wait_for_results();
      // all ones, length saturates to twenty
      load_key('1, '1, '1, '1);
      send_beat(OP_KEY_SCHED, 8'h00, 1'b0, dummy);
      send_beat(OP_DATA, 8'hff, 1'b1, dummy);
      send_beat(OP_DATA, 8'h00, 1'b0, dummy);
      wait_for_results();
      load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               64'(KLEN_MIN));
      send_beat(OP_KEY_SCHED, 8'($urandom), 1'b1, dummy);
      send_beat(OP_DATA, 8'($urandom), 1'b1, dummy);
      wait_for_results();
      load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               64'(KLEN_MAX));
      send_beat(OP_KEY_SCHED, 8'($urandom), 1'b0, dummy);
      send_beat(OP_DATA, 8'($urandom), 1'b0, dummy);
      // restart mid stream
      send_beat(OP_KEY_SCHED, 8'($urandom), 1'b1, dummy);
      send_beat(OP_DATA, 8'($urandom), 1'b1, dummy);
      wait_for_results();
   endtask

   task automatic test_round_trip();
      logic [BYTE_W-1:0] plain [4];
      logic [BYTE_W-1:0] cipher [4];
      logic [BYTE_W-1:0] dummy;
      load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               64'(KLEN_RST));
      send_beat(OP_KEY_SCHED, 8'h00, 1'b1, dummy);
      for (int n = 0; n < 4; n++) begin
         plain[n] = 8'($urandom);
         send_beat(OP_DATA, plain[n], 1'b1, cipher[n]);
      end
      send_beat(OP_KEY_SCHED, 8'h00, 1'b0, dummy);
      for (int n = 0; n < 4; n++) send_beat(OP_DATA, cipher[n], 1'b0, dummy);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      logic [BYTE_W-1:0] dummy;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               64'($urandom_range(1, MAX_KEY)));
      send_beat(OP_KEY_SCHED, 8'($urandom), 1'($urandom), dummy);
      wait_for_results();
      hold_cycles = 300;
      repeat (30) send_beat(OP_DATA, 8'($urandom), 1'($urandom), dummy);
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      int unsigned src_pct [4]  = '{0, 54, 0, 24};
      int unsigned sink_pct [4] = '{0, 0, 54, 24};
      int unsigned sent;
      int unsigned pick;
      logic [63:0] low_word;
      logic [63:0] mid_word;
      logic [63:0] high_word;
      logic [KLEN_W-1:0] len;
      logic [BYTE_W-1:0] dummy;
      for (int phase = 0; phase < 4; phase++) begin
         src_idle_pct   = src_pct[phase];
         sink_stall_pct = sink_pct[phase];
         sent = 0;
         while (sent < 360) begin
            pick = $urandom_range(9);
            low_word  = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
            mid_word  = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
            high_word = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
            pick = $urandom_range(9);
            case (pick)
               0: len = '0;
               1: len = KLEN_MIN;
               2: len = KLEN_MAX;
               3: len = '1;
               default: len = KLEN_W'($urandom_range(1, MAX_KEY));
            endcase
            load_key(low_word, mid_word, high_word, {$urandom, 27'($urandom), len});
            send_beat(OP_KEY_SCHED, 8'($urandom), 1'($urandom), dummy);
            sent++;
            repeat ($urandom_range(20, 120)) begin
               if ($urandom_range(99) < 2)
                  send_beat(OP_KEY_SCHED, 8'($urandom), 1'($urandom), dummy);
               else
                  send_beat(OP_DATA, 8'($urandom), 1'($urandom), dummy);
               sent++;
            end
            wait_for_results();
         end
      end
   endtask

   initial begin : response_checker
      cipher_result_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: response beat with none expected, actual %02h/%0b", $time,
                        rsp_bus.result_byte, rsp_bus.was_key_schedule);
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.result_byte !== want.result_byte) begin
                  mismatch_count++;
                  $display("%0t: result_byte expected %02h actual %02h", $time,
                           want.result_byte, rsp_bus.result_byte);
               end
               if (rsp_bus.was_key_schedule !== want.was_key_schedule) begin
                  mismatch_count++;
                  $display("%0t: was_key_schedule expected %0b actual %0b", $time,
                           want.was_key_schedule, rsp_bus.was_key_schedule);
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_KEY_LOW;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.op        <= OP_KEY_SCHED;
      req_bus.data_byte <= '0;
      req_bus.encrypt   <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_key_extremes();
      test_round_trip();
      test_backpressure();
      test_random_traffic();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("rc4_feedback_stream_cipher_tb: PASS");
      end else begin
         $display("rc4_feedback_stream_cipher_tb: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("rc4_feedback_stream_cipher_tb: FAIL");
      $finish;
   end

endmodule
